// ===== rtl/gcw_pkg.sv =====
// Shared constants and types of the grid line cell walker.
package gcw_pkg;

	localparam int COORD_BITS = 6;
	localparam int FRAC_BITS  = 16;

	localparam int CELL_W      = 6;
	localparam int IN_DATA_W   = 4 * CELL_W;
	localparam int OUT_DATA_W  = ((2 * CELL_W + 7) / 8) * 8;
	localparam int POS_W       = COORD_BITS + FRAC_BITS + 1;
	localparam int QUO_W       = FRAC_BITS + 1;
	localparam int REM_W       = COORD_BITS + 1;
	localparam int ERR_W       = COORD_BITS + 3;
	localparam int DIVC_W      = $clog2(FRAC_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic cell_last;
	} sts_t;

endpackage

// ===== rtl/gcw_ctrl.sv =====
// Controller: sequences load, increment division and cell emission.
module gcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  gcw_pkg::sts_t sts,
	output gcw_pkg::cmd_t cmd
);
	import gcw_pkg::*;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.load     = s_tvalid && (state_q == ST_IDLE);
		cmd.div_step = (state_q == ST_DIV);
		cmd.emit     = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= sts.need_div ? ST_DIV : ST_EMIT;
					end
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.emit && sts.cell_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/gcw_dpath.sv =====
// Datapath: Bresenham walker, DDA accumulators, serial divider, output register.
module gcw_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [gcw_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tuser,
	input  gcw_pkg::cmd_t                    cmd,
	output gcw_pkg::sts_t                    sts,
	output logic [gcw_pkg::CELL_W-1:0]       col,
	output logic [gcw_pkg::CELL_W-1:0]       row,
	output logic                             last
);
	import gcw_pkg::*;

	function automatic logic [COORD_BITS-1:0] cell_of(input logic [POS_W-1:0] p);
		cell_of = p[POS_W-1] ? '0 : p[FRAC_BITS +: COORD_BITS];
	endfunction

	// input decode
	logic [COORD_BITS-1:0] c1, r1, c2, r2, adx, ady, steps_in;
	logic                  xneg_in, yneg_in;

	assign c1 = s_tdata[0*CELL_W +: COORD_BITS];
	assign r1 = s_tdata[1*CELL_W +: COORD_BITS];
	assign c2 = s_tdata[2*CELL_W +: COORD_BITS];
	assign r2 = s_tdata[3*CELL_W +: COORD_BITS];
	assign xneg_in  = (c2 < c1);
	assign yneg_in  = (r2 < r1);
	assign adx      = xneg_in ? (c1 - c2) : (c2 - c1);
	assign ady      = yneg_in ? (r1 - r2) : (r2 - r1);
	assign steps_in = (adx > ady) ? adx : ady;

	// line state
	logic                    mode_q, xneg_q, yneg_q;
	logic [COORD_BITS-1:0]   c2_q, r2_q, x_q, y_q, dx_q, dy_q, steps_q, cnt_q;
	logic signed [ERR_W-1:0] err_q;
	logic [POS_W-1:0]        px_q, py_q;
	logic [REM_W-1:0]        rx_q, ry_q;
	logic [QUO_W-1:0]        qx_q, qy_q;
	logic [DIVC_W-1:0]       divc_q;

	// division lanes, one quotient bit a cycle
	logic             div_first;
	logic [REM_W-1:0] tx, ty, sd;
	logic             gx, gy;

	assign div_first = (divc_q == '0);
	assign sd = {1'b0, steps_q};
	assign tx = div_first ? rx_q : {rx_q[REM_W-2:0], 1'b0};
	assign ty = div_first ? ry_q : {ry_q[REM_W-2:0], 1'b0};
	assign gx = (tx >= sd);
	assign gy = (ty >= sd);

	// Bresenham update
	logic signed [ERR_W:0] e2, dxe, dye, err_nx;
	logic                  mv_x, mv_y;

	assign e2   = {err_q, 1'b0};
	assign dxe  = {4'b0000, dx_q};
	assign dye  = {4'b0000, dy_q};
	assign mv_x = (e2 > -dye);
	assign mv_y = (e2 < dxe);
	assign err_nx = {err_q[ERR_W-1], err_q} - (mv_x ? dye : '0) + (mv_y ? dxe : '0);

	// DDA increments
	logic [POS_W-1:0] qxe, qye, stx, sty;

	assign qxe = {{(POS_W-QUO_W){1'b0}}, qx_q};
	assign qye = {{(POS_W-QUO_W){1'b0}}, qy_q};
	assign stx = xneg_q ? -qxe : qxe;
	assign sty = yneg_q ? -qye : qye;

	// current cell
	logic [COORD_BITS-1:0] cur_col, cur_row;
	logic                  cnt_max, cur_last;

	assign cnt_max  = (cnt_q == '1);
	assign cur_col  = mode_q ? cell_of(px_q) : x_q;
	assign cur_row  = mode_q ? cell_of(py_q) : y_q;
	assign cur_last = cnt_max ||
		(mode_q ? (cnt_q == steps_q) : ((x_q == c2_q) && (y_q == r2_q)));

	always_comb begin
		sts.need_div  = s_tuser && (steps_in != '0);
		sts.div_last  = (divc_q == DIVC_W'(FRAC_BITS));
		sts.cell_last = cur_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divc_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.load) begin
			divc_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.div_step) begin
				divc_q <= divc_q + 1'b1;
			end
			if (cmd.emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= s_tuser;
			xneg_q  <= xneg_in;
			yneg_q  <= yneg_in;
			c2_q    <= c2;
			r2_q    <= r2;
			x_q     <= c1;
			y_q     <= r1;
			dx_q    <= adx;
			dy_q    <= ady;
			steps_q <= steps_in;
			err_q   <= {3'b000, adx} - {3'b000, ady};
			px_q    <= POS_W'({c1, 1'b1, {(FRAC_BITS-1){1'b0}}});
			py_q    <= POS_W'({r1, 1'b1, {(FRAC_BITS-1){1'b0}}});
			rx_q    <= {1'b0, adx};
			ry_q    <= {1'b0, ady};
			qx_q    <= '0;
			qy_q    <= '0;
		end else if (cmd.div_step) begin
			rx_q <= gx ? (tx - sd) : tx;
			ry_q <= gy ? (ty - sd) : ty;
			qx_q <= {qx_q[QUO_W-2:0], gx};
			qy_q <= {qy_q[QUO_W-2:0], gy};
		end else if (cmd.emit) begin
			px_q  <= px_q + stx;
			py_q  <= py_q + sty;
			err_q <= err_nx[ERR_W-1:0];
			if (mv_x) begin
				x_q <= xneg_q ? (x_q - 1'b1) : (x_q + 1'b1);
			end
			if (mv_y) begin
				y_q <= yneg_q ? (y_q - 1'b1) : (y_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			col  <= CELL_W'(cur_col);
			row  <= CELL_W'(cur_row);
			last <= cur_last;
		end
	end

endmodule

// ===== rtl/grid_line_cell_walker_unit.sv =====
// Mode 0: after the request transfer, one cell per cycle while the output is not stalled.
// Mode 1: a serial increment division (FRAC_BITS+1 quotient bits) comes first.
// A line has N = max(|dx|,|dy|)+1 cells, at most 64; a zero-length line skips the division.
// The next request is taken the cycle after the last cell enters the output register.
// arst_n clears the controller to idle with no result pending; payload is not reset.
module grid_line_cell_walker_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gcw_pkg::IN_DATA_W-1:0]       s_tdata,  // start_col, start_row, end_col, end_row
	input  logic                                s_tuser,  // center_mode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gcw_pkg::OUT_DATA_W-1:0]      m_tdata,  // col, row, zero pad
	output logic                                m_tlast
);
	import gcw_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [CELL_W-1:0] col, row;

	gcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gcw_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.sts     (sts),
		.col     (col),
		.row     (row),
		.last    (m_tlast)
	);

	assign m_tdata = OUT_DATA_W'({row, col});

endmodule

// ===== rtl/gcw_checker.sv =====
// Port-level checks of the grid line cell walker, bound to the top level.
module gcw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [gcw_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast
);

	default disable iff (!arst_n);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a request transfer starts a walk
	a_busy_after_req: assert property (@(posedge clk)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while walking");

	// a pending non-final cell means the line is still in progress
	a_mid_line_busy: assert property (@(posedge clk)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("idle with a line unfinished");

	// returning to idle coincides with the final cell being presented
	a_idle_on_last: assert property (@(posedge clk)
		$rose(s_tready) |-> m_tvalid && m_tlast)
		else $error("idle without final cell");

endmodule

bind grid_line_cell_walker_unit gcw_checker u_gcw_checker (.*);

// ===== bench/tb_grid_line_cell_walker_unit.sv =====
// Testbench for grid_line_cell_walker_unit: checks each cell on a line against a local line tracer.
`timescale 1ns / 1ps

module tb_grid_line_cell_walker_unit;
	import gcw_pkg::*;

	typedef struct {
		logic [5:0] col;
		logic [5:0] row;
		logic       last;
	} cell_t;

	localparam int MAX_CELLS  = 1 << COORD_BITS;
	localparam int COORD_MASK = MAX_CELLS - 1;
	localparam logic MODE_BRESENHAM = 1'b0;
	localparam logic MODE_CENTER    = 1'b1;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // start_col, start_row, end_col, end_row
	logic                  s_tuser;   // center_mode
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // col, row, zero pad
	logic                  m_tlast;

	cell_t cell_q[$];
	cell_t exp_cell;
	int    mismatches = 0;
	int    rx_hold_cycles = 0;
	bit    tx_no_gaps = 0;
	bit    rx_no_gaps = 0;

	grid_line_cell_walker_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int abs_int(input int v);
		return v < 0 ? -v : v;
	endfunction

	// Signed fixed-point increment, magnitude truncated toward zero
	function automatic int frac_step(input int delta, input int steps);
		int unsigned mag;
		mag = (int'(abs_int(delta)) << FRAC_BITS) / steps;
		return delta < 0 ? -int'(mag) : int'(mag);
	endfunction

	function automatic logic [5:0] cell_of(input int pos);
		if (pos < 0)
			return 6'd0;
		return 6'((pos >>> FRAC_BITS) & 63);
	endfunction

	function automatic void trace_line(input logic [5:0] sc, sr, ec, er, input logic mode);
		int c1, r1, c2, r2, dx, dy, x, y, sx, sy, err, e2, steps, px, py, xi, yi, n;
		bit done;
		cell_t nxt;
		c1 = int'(sc) & COORD_MASK;
		r1 = int'(sr) & COORD_MASK;
		c2 = int'(ec) & COORD_MASK;
		r2 = int'(er) & COORD_MASK;
		dx = abs_int(c2 - c1);
		dy = abs_int(r2 - r1);
		if (mode == MODE_BRESENHAM) begin
			x = c1;
			y = r1;
			sx = (c1 < c2) ? 1 : -1;
			sy = (r1 < r2) ? 1 : -1;
			err = dx - dy;
			for (n = 0; n < MAX_CELLS; n++) begin
				done = (x == c2 && y == r2) || n == MAX_CELLS - 1;
				e2 = 2 * err;
				nxt.col = 6'(x & 63);
				nxt.row = 6'(y & 63);
				nxt.last = done;
				cell_q.insert(cell_q.size(), nxt);
				if (done)
					break;
				if (e2 > -dy) begin
					err -= dy;
					x += sx;
				end
				if (e2 < dx) begin
					err += dx;
					y += sy;
				end
			end
		end else begin
			steps = dx > dy ? dx : dy;
			px = (c1 << FRAC_BITS) + (1 << (FRAC_BITS - 1));
			py = (r1 << FRAC_BITS) + (1 << (FRAC_BITS - 1));
			xi = 0;
			yi = 0;
			if (steps != 0) begin
				xi = frac_step(c2 - c1, steps);
				yi = frac_step(r2 - r1, steps);
			end
			for (n = 0; n <= steps && n < MAX_CELLS; n++) begin
				nxt.col = cell_of(px);
				nxt.row = cell_of(py);
				nxt.last = (n == steps) || (n == MAX_CELLS - 1);
				cell_q.insert(cell_q.size(), nxt);
				px += xi;
				py += yi;
			end
		end
	endfunction

	task automatic send_line(input logic [5:0] c1, r1, c2, r2, input logic mode);
		int unsigned gap;
		gap = tx_no_gaps ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {r2, c2, r1, c1};
		s_tuser <= mode;
		do @(posedge clk); while (!s_tready);
		trace_line(c1, r1, c2, r2, mode);
	endtask

	// Receiver: per-result random stall, plus an optional long hold-off
	initial begin
		int unsigned gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_cycles > 0) begin
				repeat (rx_hold_cycles) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
				rx_hold_cycles = 0;
			end
			gap = rx_no_gaps ? 0 : $urandom_range(0, 12);
			repeat (gap) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && rx_hold_cycles == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (cell_q.size() == 0) begin
				$display("%0t: unexpected cell col %0d row %0d last %0b", $realtime,
					m_tdata[5:0], m_tdata[11:6], m_tlast);
				mismatches++;
			end else begin
				exp_cell = cell_q.pop_front();
				if (m_tdata[5:0] !== exp_cell.col) begin
					$display("%0t: col expected %0d actual %0d", $realtime,
						exp_cell.col, m_tdata[5:0]);
					mismatches++;
				end
				if (m_tdata[11:6] !== exp_cell.row) begin
					$display("%0t: row expected %0d actual %0d", $realtime,
						exp_cell.row, m_tdata[11:6]);
					mismatches++;
				end
				if (m_tlast !== exp_cell.last) begin
					$display("%0t: last expected %0b actual %0b", $realtime,
						exp_cell.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// Corners, diagonals, axis-aligned, steep and shallow lines in both modes
	task automatic test_directed_lines();
		logic mode;
		for (int m = 0; m < 2; m++) begin
			mode = m ? MODE_CENTER : MODE_BRESENHAM;
			send_line(6'd0, 6'd0, 6'd63, 6'd63, mode);
			send_line(6'd63, 6'd63, 6'd0, 6'd0, mode);
			send_line(6'd0, 6'd63, 6'd63, 6'd0, mode);
			send_line(6'd63, 6'd0, 6'd0, 6'd63, mode);
			send_line(6'd0, 6'd5, 6'd63, 6'd5, mode);
			send_line(6'd7, 6'd0, 6'd7, 6'd63, mode);
			send_line(6'd10, 6'd10, 6'd13, 6'd40, mode);
			send_line(6'd50, 6'd3, 6'd2, 6'd9, mode);
		end
	endtask

	task automatic test_zero_length();
		send_line(6'd0, 6'd0, 6'd0, 6'd0, MODE_BRESENHAM);
		send_line(6'd63, 6'd63, 6'd63, 6'd63, MODE_BRESENHAM);
		send_line(6'd0, 6'd0, 6'd0, 6'd0, MODE_CENTER);
		send_line(6'd63, 6'd63, 6'd63, 6'd63, MODE_CENTER);
	endtask

	// Receiver holds off while requests keep coming back to back
	task automatic test_output_backpressure();
		tx_no_gaps = 1;
		rx_hold_cycles = 300;
		for (int i = 0; i < 6; i++)
			send_line(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
				6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
		tx_no_gaps = 0;
	endtask

	task automatic test_random_lines(input int count);
		int c1, r1, c2, r2;
		for (int i = 0; i < count; i++) begin
			if (i % 48 == 0) begin
				tx_no_gaps = ($urandom_range(0, 3) == 0);
				rx_no_gaps = ($urandom_range(0, 3) == 0);
			end
			c1 = $urandom_range(0, 63);
			r1 = $urandom_range(0, 63);
			if ($urandom_range(0, 2) == 0) begin
				c2 = c1 + int'($urandom_range(0, 8)) - 4;
				r2 = r1 + int'($urandom_range(0, 8)) - 4;
				c2 = c2 < 0 ? 0 : (c2 > 63 ? 63 : c2);
				r2 = r2 < 0 ? 0 : (r2 > 63 ? 63 : r2);
			end else begin
				c2 = $urandom_range(0, 63);
				r2 = $urandom_range(0, 63);
			end
			send_line(6'(c1), 6'(r1), 6'(c2), 6'(r2), 1'($urandom_range(0, 1)));
		end
		tx_no_gaps = 0;
		rx_no_gaps = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_lines();
		test_zero_length();
		test_output_backpressure();
		test_random_lines(354);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (cell_q.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
